// ===== sv/ctst_pkg.sv =====
`default_nettype none

package ctst_pkg;

  // fixed field and register widths
  localparam int COUNT_BITS  = 48;
  localparam int FRAC_BITS   = 16;
  localparam int PERIOD_BITS = 48;
  localparam int DATA_BITS   = 64;
  localparam int ADDR_BITS   = 5;

  // scaled count and the widths of the derived periods
  localparam int WIDE_BITS = COUNT_BITS + FRAC_BITS;
  localparam int MIN_BITS  = PERIOD_BITS + 6;
  localparam int HOUR_BITS = PERIOD_BITS + 12;
  localparam int R_BITS    = (WIDE_BITS > HOUR_BITS) ? WIDE_BITS : HOUR_BITS;

  localparam int SECS_PER_MIN  = 60;
  localparam int SECS_PER_HOUR = 3600;

  // quotient bits per division phase
  localparam int HOUR_STEPS = WIDE_BITS;
  localparam int MIN_STEPS  = 6;
  localparam int SEC_STEPS  = 6;
  localparam int FRM_STEPS  = PERIOD_BITS;
  localparam int SUB_STEPS  = PERIOD_BITS;
  localparam int NSTG = HOUR_STEPS + MIN_STEPS + SEC_STEPS + FRM_STEPS + SUB_STEPS;

  localparam logic [PERIOD_BITS-1:0] FRAME_RST  = PERIOD_BITS'(64'd2730666667);
  localparam logic [PERIOD_BITS-1:0] SUB_RST    = PERIOD_BITS'(64'd34133333);
  localparam logic [PERIOD_BITS-1:0] SECOND_RST = PERIOD_BITS'(64'd3145728000);

  localparam logic [7:0] HOURS_MAX     = 8'd255;
  localparam logic [7:0] FRAMES_MAX    = 8'd255;
  localparam logic [9:0] SUBFRAMES_MAX = 10'd1023;

  typedef enum logic [1:0] {
    REG_FRAME  = 2'd0,
    REG_SUB    = 2'd1,
    REG_SECOND = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HOUR,
    PH_MIN,
    PH_SEC,
    PH_FRM,
    PH_SUB
  } phase_t;

  // one in-flight conversion
  typedef struct packed {
    logic [R_BITS-1:0] r;
    logic [9:0]        q;
    logic              psat;
    logic              ovf;
    logic [7:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
    logic [7:0]        frames;
  } rec_t;

  function automatic phase_t stage_phase(input int k);
    phase_t p;
    if (k < HOUR_STEPS) p = PH_HOUR;
    else if (k < HOUR_STEPS + MIN_STEPS) p = PH_MIN;
    else if (k < HOUR_STEPS + MIN_STEPS + SEC_STEPS) p = PH_SEC;
    else if (k < HOUR_STEPS + MIN_STEPS + SEC_STEPS + FRM_STEPS) p = PH_FRM;
    else p = PH_SUB;
    return p;
  endfunction

  // quotient bit weight handled by stage k
  function automatic int stage_bit(input int k);
    int b;
    if (k < HOUR_STEPS) b = HOUR_STEPS - 1 - k;
    else if (k < HOUR_STEPS + MIN_STEPS) b = HOUR_STEPS + MIN_STEPS - 1 - k;
    else if (k < HOUR_STEPS + MIN_STEPS + SEC_STEPS)
      b = HOUR_STEPS + MIN_STEPS + SEC_STEPS - 1 - k;
    else if (k < HOUR_STEPS + MIN_STEPS + SEC_STEPS + FRM_STEPS)
      b = HOUR_STEPS + MIN_STEPS + SEC_STEPS + FRM_STEPS - 1 - k;
    else b = NSTG - 1 - k;
    return b;
  endfunction

  function automatic int phase_cap(input phase_t p);
    int w;
    case (p)
      PH_HOUR: w = 8;
      PH_MIN:  w = 6;
      PH_SEC:  w = 6;
      PH_FRM:  w = 8;
      PH_SUB:  w = 10;
      default: w = 10;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/count_to_smpte_timecode.sv =====
`default_nettype none
// count to smpte timecode converter
// input channel: in_valid / in_ready carry one request, time_count, an absolute
// position in ns or samples. output channel: out_valid / out_ready carry
// hours, minutes, seconds, frames, subframes and the overflow flag.
// the apb port holds frame, subframe and second periods (unsigned q32.16) at
// byte addresses 0, 8 and 16; write them only while no request is in flight.
// the count, scaled by 2^16, is split by restoring division, one quotient bit
// per pipeline stage: hours, then minutes, seconds, frames, subframes.
// the request is taken into the input register, then passes one
// compare-and-subtract stage per quotient bit; the last stage drives the
// result ports.
// one request per cycle while not stalled; every stage holds its own valid bit.
// when a result waits with out_ready low the whole pipe holds and in_ready
// drops with it, so nothing is lost or repeated; bubbles flow through while
// the sink accepts.
// reset empties the pipe and loads the period registers with their defaults;
// minute and hour periods are registered multiples of the second period,
// refreshed every cycle.
module count_to_smpte_timecode
  import ctst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COUNT_BITS-1:0]  time_count,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  hours,
  output logic [5:0]                  minutes,
  output logic [5:0]                  seconds,
  output logic [7:0]                  frames,
  output logic [9:0]                  subframes,
  output logic                        overflow,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ADDR_BITS-1:0]   paddr,
  input  wire logic [DATA_BITS-1:0]   pwdata,
  output logic [DATA_BITS-1:0]        prdata,
  output logic                        pready
);

  logic [PERIOD_BITS-1:0] frame_period;
  logic [PERIOD_BITS-1:0] subframe_period;
  logic [PERIOD_BITS-1:0] second_period;

  // zero periods count as one lsb
  logic [PERIOD_BITS-1:0] frp;
  logic [PERIOD_BITS-1:0] sfp;
  logic [PERIOD_BITS-1:0] secp;
  logic [MIN_BITS-1:0]    minp;
  logic [HOUR_BITS-1:0]   hourp;

  logic [1:0] widx;
  logic       wr;
  logic       en;

  rec_t             stg [0:NSTG];
  rec_t             nxt [0:NSTG-1];
  logic [NSTG:0]    vld;

  assign pready = 1'b1;
  assign widx   = paddr[ADDR_BITS-1:3];
  assign wr     = psel && penable && pwrite && pready;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period    <= FRAME_RST;
      subframe_period <= SUB_RST;
      second_period   <= SECOND_RST;
    end else if (wr) begin
      case (widx)
        REG_FRAME:  frame_period    <= pwdata[PERIOD_BITS-1:0];
        REG_SUB:    subframe_period <= pwdata[PERIOD_BITS-1:0];
        REG_SECOND: second_period   <= pwdata[PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_FRAME:  prdata = DATA_BITS'(frame_period);
      REG_SUB:    prdata = DATA_BITS'(subframe_period);
      REG_SECOND: prdata = DATA_BITS'(second_period);
      default:    prdata = '0;
    endcase
  end

  // derived divisors; kept stable while requests are in flight by the user alone
  always_ff @(posedge clk) begin
    frp   <= (frame_period == '0) ? PERIOD_BITS'(1) : frame_period;
    sfp   <= (subframe_period == '0) ? PERIOD_BITS'(1) : subframe_period;
    secp  <= (second_period == '0) ? PERIOD_BITS'(1) : second_period;
    minp  <= MIN_BITS'((second_period == '0) ? PERIOD_BITS'(1) : second_period)
             * MIN_BITS'(SECS_PER_MIN);
    hourp <= HOUR_BITS'((second_period == '0) ? PERIOD_BITS'(1) : second_period)
             * HOUR_BITS'(SECS_PER_HOUR);
  end

  // the whole pipe advances unless the output holds a request not taken
  assign en       = !vld[NSTG] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= '{r: R_BITS'({time_count, {FRAC_BITS{1'b0}}}), default: '0};
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam phase_t PH  = stage_phase(k);
    localparam int     BIT = stage_bit(k);
    localparam bit     LOW = (BIT < phase_cap(PH));

    logic [R_BITS-1:0] d;
    logic              take;

    always_comb begin
      case (PH)
        PH_HOUR: d = R_BITS'(hourp);
        PH_MIN:  d = R_BITS'(minp);
        PH_SEC:  d = R_BITS'(secp);
        PH_FRM:  d = R_BITS'(frp);
        default: d = R_BITS'(sfp);
      endcase
    end

    always_comb begin
      nxt[k] = stg[k];
      take   = (stg[k].r >> BIT) >= d;
      if (take) begin
        nxt[k].r = stg[k].r - (d << BIT);
      end
      nxt[k].q    = stg[k].q | ({9'b0, take & LOW} << BIT);
      nxt[k].psat = stg[k].psat | (take & !LOW);
      // close each phase but subframes: store the field, restart the quotient
      if (BIT == 0) begin
        case (PH)
          PH_HOUR: nxt[k].hours   = nxt[k].psat ? HOURS_MAX : nxt[k].q[7:0];
          PH_MIN:  nxt[k].minutes = nxt[k].q[5:0];
          PH_SEC:  nxt[k].seconds = nxt[k].q[5:0];
          PH_FRM:  nxt[k].frames  = nxt[k].psat ? FRAMES_MAX : nxt[k].q[7:0];
          default: ;
        endcase
        if (PH != PH_SUB) begin
          nxt[k].ovf  = nxt[k].ovf | nxt[k].psat;
          nxt[k].q    = '0;
          nxt[k].psat = 1'b0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k+1] <= nxt[k];
      end
    end
  end

  assign out_valid = vld[NSTG];
  assign hours     = stg[NSTG].hours;
  assign minutes   = stg[NSTG].minutes;
  assign seconds   = stg[NSTG].seconds;
  assign frames    = stg[NSTG].frames;
  assign subframes = stg[NSTG].psat ? SUBFRAMES_MAX : stg[NSTG].q;
  assign overflow  = stg[NSTG].ovf | stg[NSTG].psat;

  // remainder after the hour phase is below the hour period
  a_hour_rem: assert property (@(posedge clk) disable iff (rst)
    vld[HOUR_STEPS] |-> (stg[HOUR_STEPS].r < R_BITS'(hourp)))
    else $error("hour remainder not reduced");

  a_min_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (minutes <= 6'd59 && seconds <= 6'd59))
    else $error("minutes or seconds out of range");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted request lost at pipe entry");

  a_sub_rem: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG - SUB_STEPS] |-> (stg[NSTG - SUB_STEPS].r < R_BITS'(frp)))
    else $error("frame remainder not reduced");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import ctst_pkg::*;

  localparam int  LIMIT_CYCLES = 2_000_000;
  localparam int  DRAIN_CYCLES = NSTG + 40;   // pipe depth plus margin
  localparam logic [PERIOD_BITS-1:0] PERIOD_ALL_ONES = '1;

  // one converted position, as the block reports it
  typedef struct packed {
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] frames;
    logic [9:0] subframes;
    logic       overflow;
  } timecode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COUNT_BITS-1:0] time_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] hours;
  logic [5:0] minutes;
  logic [5:0] seconds;
  logic [7:0] frames;
  logic [9:0] subframes;
  logic overflow;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  count_to_smpte_timecode u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .time_count(time_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .hours(hours), .minutes(minutes), .seconds(seconds), .frames(frames),
    .subframes(subframes), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the period registers
  logic [PERIOD_BITS-1:0] frame_len  = FRAME_RST;
  logic [PERIOD_BITS-1:0] sub_len    = SUB_RST;
  logic [PERIOD_BITS-1:0] second_len = SECOND_RST;

  timecode_t pending_timecodes[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;      // receiver hold-off, counted down by the sink process

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // split a position the same way the block does: exact fixed point,
  // count scaled by 2^FRAC_BITS, floor division phase by phase
  function automatic timecode_t split_timecode(input logic [COUNT_BITS-1:0] pos);
    logic [63:0] scaled, sec_p, min_p, hour_p, frm_p, sub_p, q, rem;
    timecode_t tc;
    sec_p  = (second_len == 0) ? 64'd1 : 64'(second_len);
    frm_p  = (frame_len == 0) ? 64'd1 : 64'(frame_len);
    sub_p  = (sub_len == 0) ? 64'd1 : 64'(sub_len);
    min_p  = sec_p * 64'd60;
    hour_p = min_p * 64'd60;
    scaled = {pos, 16'b0};
    tc.overflow = 1'b0;
    q = scaled / hour_p;
    rem = scaled % hour_p;
    // saturated fields still hand the exact remainder down
    if (q > 64'(HOURS_MAX)) begin
      tc.hours = HOURS_MAX;
      tc.overflow = 1'b1;
    end else begin
      tc.hours = q[7:0];
    end
    q = rem / min_p;
    rem = rem % min_p;
    tc.minutes = (q > 64'd59) ? 6'd59 : q[5:0];
    q = rem / sec_p;
    rem = rem % sec_p;
    tc.seconds = (q > 64'd59) ? 6'd59 : q[5:0];
    q = rem / frm_p;
    rem = rem % frm_p;
    if (q > 64'(FRAMES_MAX)) begin
      tc.frames = FRAMES_MAX;
      tc.overflow = 1'b1;
    end else begin
      tc.frames = q[7:0];
    end
    q = rem / sub_p;
    if (q > 64'(SUBFRAMES_MAX)) begin
      tc.subframes = SUBFRAMES_MAX;
      tc.overflow = 1'b1;
    end else begin
      tc.subframes = q[9:0];
    end
    return tc;
  endfunction

  // sink: random stalls, or a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_field(input string name, input logic [9:0] want,
                              input logic [9:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    timecode_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_timecodes.size() == 0) begin
        $display("%0t unexpected result expected none actual %0d:%0d:%0d:%0d.%0d ovf %0d",
                 $time, hours, minutes, seconds, frames, subframes, overflow);
        errors++;
      end else begin
        want = pending_timecodes.pop_front();
        report_field("hours", 10'(want.hours), 10'(hours));
        report_field("minutes", 10'(want.minutes), 10'(minutes));
        report_field("seconds", 10'(want.seconds), 10'(seconds));
        report_field("frames", 10'(want.frames), 10'(frames));
        report_field("subframes", want.subframes, subframes);
        report_field("overflow", 10'(want.overflow), 10'(overflow));
      end
    end
  end

  // one request; valid stays high into the next request when back to back
  task automatic send_position(input logic [COUNT_BITS-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    time_count <= pos;
    do @(posedge clk); while (!in_ready);
    pending_timecodes.push_back(split_timecode(pos));
  endtask

  // stop offering and wait until every result is back and the pipe is empty
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_timecodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input reg_idx_t idx, input logic [PERIOD_BITS-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(idx) << 3;
    pwdata <= DATA_BITS'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FRAME:  frame_len = val;
      REG_SUB:    sub_len = val;
      REG_SECOND: second_len = val;
      default: ;
    endcase
  endtask

  task automatic set_periods(input logic [PERIOD_BITS-1:0] frm,
                             input logic [PERIOD_BITS-1:0] sub,
                             input logic [PERIOD_BITS-1:0] sec);
    wait_drained();
    write_period(REG_FRAME, frm);
    write_period(REG_SUB, sub);
    write_period(REG_SECOND, sec);
  endtask

  function automatic logic [PERIOD_BITS-1:0] rand_period();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return PERIOD_BITS'(r);
      1: return PERIOD_BITS'(r) >> $urandom_range(47);
      2: return PERIOD_BITS'($urandom_range(3));
      default: return PERIOD_BITS'(r[31:0]) + 1;
    endcase
  endfunction

  // realistic rate: units per second and frames per second, 80 subframes
  task automatic set_rate(input int units, input int fps);
    logic [PERIOD_BITS-1:0] sec;
    sec = PERIOD_BITS'(units) << FRAC_BITS;
    set_periods(sec / fps, sec / (fps * 80), sec);
  endtask

  function automatic logic [COUNT_BITS-1:0] rand_position();
    logic [63:0] r;
    logic [COUNT_BITS-1:0] sec_units;
    r = {$urandom, $urandom};
    sec_units = (second_len >> FRAC_BITS) + 1;
    case ($urandom_range(4))
      0: return COUNT_BITS'(r);
      1: return COUNT_BITS'(r[31:0]);
      // just around whole seconds, minutes and hours
      2: return sec_units * $urandom_range(4000) + $urandom_range(3) - 2;
      3: return COUNT_BITS'(r) >> $urandom_range(47);
      default: return sec_units * 3600 * $urandom_range(300) - $urandom_range(1);
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_position(rand_position());
  endtask

  // reset values, field extremes, boundaries
  task automatic test_directed();
    send_position('0);
    send_position('1);
    send_position(48'd1);
    send_position(48'd48000);
    send_position(48'd47999);
    send_position(48'd2879999);
    send_position(48'd172800000);
    send_position(48'd172799999);
    send_position(48'd44064000000);   // 255 hours at 48k units per second
    send_position(48'd44236800000);   // past the hours limit
    send_position(48'h8000_0000_0000);
    send_position(48'h5555_5555_5555);
    send_position(48'hAAAA_AAAA_AAAA);
  endtask

  // a zero period behaves as one lsb; all-ones periods; frame longer than second
  task automatic test_extreme_periods();
    set_periods('0, '0, '0);
    send_position('0);
    send_position(48'd1);
    send_position('1);
    set_periods(PERIOD_ALL_ONES, PERIOD_ALL_ONES, PERIOD_ALL_ONES);
    send_position('1);
    send_position(48'd12345);
    set_periods(48'd1, 48'd1, PERIOD_ALL_ONES);
    send_position('1);
    send_position(48'd7);
    set_periods(PERIOD_ALL_ONES, 48'd1, 48'd65536);
    send_position(48'd59);
    send_position(48'd3599);
  endtask

  task automatic test_rates();
    logic [PERIOD_BITS-1:0] frm;
    set_rate(48000, 25);
    send_random(150);
    // 29.97 over nanoseconds: the second spans 30 frames
    frm = PERIOD_BITS'((64'd1000000000 * 64'd65536 * 64'd100 + 64'd1498) / 64'd2997);
    set_periods(frm, frm / 80, frm * 30);
    send_random(150);
    set_rate(44100, 24);
    send_random(150);
  endtask

  // pipe stalls while the sink holds off, then the source pauses until empty
  task automatic test_backpressure();
    wait_drained();
    hold_left = 400;
    send_random(300);
    wait_drained();
    send_random(100);
  endtask

  task automatic test_random_periods(input int sets, input int per_set);
    repeat (sets) begin
      set_periods(rand_period(), rand_period(), rand_period());
      send_random(per_set);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_extreme_periods();

    // busy source, slow sink
    send_idle_pct = 18;
    recv_idle_pct = 73;
    test_rates();
    test_random_periods(4, 50);

    // slow source, busy sink
    send_idle_pct = 73;
    recv_idle_pct = 18;
    test_backpressure();
    test_random_periods(4, 50);

    // no idling either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_periods(5, 60);
    set_periods(FRAME_RST, SUB_RST, SECOND_RST);
    send_random(330);

    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
